@@ sv/i2ctrf_pkg.sv @@
// Shared types and constants for the I2C target register file.
// No dependencies; every other file of the block except i2ctrf_ram imports this package.
package i2ctrf_pkg;

  localparam logic [1:0] OP_WR_MATCH = 2'd0;
  localparam logic [1:0] OP_DATA     = 2'd1;
  localparam logic [1:0] OP_RD_MATCH = 2'd2;

  localparam logic [7:0] CHAR_ARM_READ = 8'h4D;
  localparam logic [7:0] CHAR_RESET    = 8'h52;

  typedef struct packed {
    logic [1:0] opcode;
    logic       general_call;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       led_off;
  } result_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

@@ sv/i2ctrf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2ctrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/i2ctrf_ctrl.sv @@
// Controller state machine: clearing pass, idle, event execution.
// Depends on i2ctrf_pkg for the state and command/status types.
module i2ctrf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  output i2ctrf_pkg::ctrl_cmd_t  cmd_o,
  input  i2ctrf_pkg::dp_status_t sts_i
);

  import i2ctrf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy_o           = 1'b1;
    cmd_o.accept     = 1'b0;
    cmd_o.clear_step = 1'b0;
    cmd_o.exec       = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/i2ctrf_dp.sv @@
// Datapath: pointer, pending flags, clear counter, byte store and result register.
// Depends on i2ctrf_pkg and i2ctrf_ram.
module i2ctrf_dp #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2ctrf_pkg::ctrl_cmd_t  cmd_i,
  output i2ctrf_pkg::dp_status_t sts_o,
  input  i2ctrf_pkg::in_item_t   in_item_i,
  output logic                   result_valid_o,
  output i2ctrf_pkg::result_t    result_o
);

  import i2ctrf_pkg::*;

  localparam int unsigned PW = $clog2(STORE_DEPTH);
  localparam int unsigned MW = PW + 4;
  localparam logic [MW-1:0] DEPTH_M = MW'(STORE_DEPTH);
  localparam logic [PW:0]   DEPTH_S = (PW+1)'(STORE_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(STORE_DEPTH - 1);
  localparam logic [PW-1:0] LED_IDX = PW'(1);

  in_item_t      item_q;
  result_t       res_q, res_d;
  logic          res_vld_q;
  logic [PW-1:0] ptr_q, ptr_d;
  logic          off_q, off_d;
  logic          dat_q, dat_d;
  logic          bc_q, bc_d;
  logic          arm_q, arm_d;
  logic [PW-1:0] clr_q;

  logic          ram_we, exec_we;
  logic [PW-1:0] ram_waddr, exec_waddr;
  logic [7:0]    ram_wdata, exec_wdata;
  logic [7:0]    ram_rdata;
  logic [PW-1:0] ptr_adv;

  always_comb begin
    logic [MW-1:0] r;
    logic [PW:0]   s;
    r = MW'(item_q.rx_byte);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (DEPTH_M << k)) r = r - (DEPTH_M << k);
    end
    s = (PW+1)'(ptr_q) + (PW+1)'(r);
    if (s >= DEPTH_S) begin
      ptr_adv = PW'(s - DEPTH_S);
    end else begin
      ptr_adv = PW'(s);
    end
  end

  always_comb begin
    ptr_d      = ptr_q;
    off_d      = off_q;
    dat_d      = dat_q;
    bc_d       = bc_q;
    arm_d      = arm_q;
    exec_we    = 1'b0;
    exec_waddr = ptr_q;
    exec_wdata = item_q.rx_byte;
    res_d      = '0;
    if (cmd_i.exec) begin
      case (item_q.opcode)
        OP_WR_MATCH: begin
          bc_d  = bc_q | item_q.general_call;
          off_d = 1'b1;
        end
        OP_DATA: begin
          if (off_q && !bc_q) begin
            off_d = 1'b0;
            dat_d = 1'b1;
            if (item_q.rx_byte == CHAR_ARM_READ) begin
              arm_d = 1'b1;
            end else begin
              arm_d = 1'b0;
              ptr_d = ptr_adv;
            end
          end else if (dat_q && !arm_q && !bc_q) begin
            exec_we = 1'b1;
            off_d   = 1'b0;
            dat_d   = 1'b0;
            ptr_d   = '0;
          end else if (dat_q && arm_q && !bc_q) begin
            ptr_d = ptr_adv;
            off_d = 1'b0;
            dat_d = 1'b0;
          end else if (bc_q) begin
            bc_d  = 1'b0;
            off_d = 1'b0;
            dat_d = 1'b0;
            if (item_q.rx_byte == CHAR_RESET) begin
              exec_we       = 1'b1;
              exec_waddr    = LED_IDX;
              exec_wdata    = '0;
              res_d.led_off = 1'b1;
            end
          end
        end
        OP_RD_MATCH: begin
          res_d.tx_valid = 1'b1;
          res_d.tx_byte  = ram_rdata;
          ptr_d          = '0;
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = exec_we;
      ram_waddr = exec_waddr;
      ram_wdata = exec_wdata;
    end
  end

  assign sts_o.clear_last = cmd_i.clear_step && (clr_q == LAST_IDX);

  i2ctrf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.accept),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      off_q     <= 1'b0;
      dat_q     <= 1'b0;
      bc_q      <= 1'b0;
      arm_q     <= 1'b0;
      clr_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      off_q     <= off_d;
      dat_q     <= dat_d;
      bc_q      <= bc_d;
      arm_q     <= arm_d;
      res_vld_q <= cmd_i.exec;
      if (cmd_i.clear_step) clr_q <= clr_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_item_i;
    if (cmd_i.exec) res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

@@ sv/i2c_target_register_file_core.sv @@
// Top level of the I2C target register file: controller plus datapath.
// Depends on i2ctrf_pkg, i2ctrf_ctrl, i2ctrf_dp and i2ctrf_ram.
//
// Usage:
//   Input channel: present one bus event on in_item_i and raise start; the
//   event is taken at a rising edge where start is high and busy is low.
//   Result channel: every event yields one result on result_o, marked by a
//   one-cycle result_valid_o strobe, registered at the end of the execute state. The
//   receiver cannot stall; each strobe must be captured when it appears.
//   No new event is taken until the last has executed. The byte store is a
//   single RAM with registered read: the read at the pointer starts on the
//   taking edge, and the update and any store write happen in the following
//   execute cycle. The next event may be offered while the previous result
//   is on the ports. Reset: pointer and pending flags clear at once; then a
//   clearing pass writes zero to every store entry, one per cycle, during
//   which busy stays high.
module i2c_target_register_file_core #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  i2ctrf_pkg::in_item_t in_item_i,
  output logic                 result_valid_o,
  output i2ctrf_pkg::result_t  result_o
);

  import i2ctrf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  i2ctrf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  i2ctrf_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_item_i     (in_item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

@@ sv/i2ctrf_chk.sv @@
// Port-level checker for the I2C target register file and its bind.
// Depends on i2ctrf_pkg and i2c_target_register_file_core.
module i2ctrf_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input i2ctrf_pkg::result_t result_o
);

  import i2ctrf_pkg::*;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("transaction without result strobe");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low right after transaction");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.tx_valid) |-> (result_o.tx_byte == 8'h00))
    else $error("tx_byte nonzero without tx_valid");

  a_read_no_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.tx_valid) |-> !result_o.led_off)
    else $error("led_off on a read result");

endmodule

bind i2c_target_register_file_core i2ctrf_chk u_chk (.*);

@@ bench/i2c_target_register_file_core_tb.sv @@
// Testbench for i2c_target_register_file_core: directed and random bus events,
// each response checked against an in-bench prediction of the register map.
// Depends on i2ctrf_pkg and the i2c_target_register_file_core RTL.
module i2c_target_register_file_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2ctrf_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_item_t in_item_i = '0;
  logic     result_valid_o;
  result_t  result_o;

  i2c_target_register_file_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_item_i     (in_item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0] shadow_store [STORE_DEPTH];
  logic [7:0] shadow_pointer;
  logic       offset_pending;
  logic       data_pending;
  logic       broadcast_pending;
  logic       read_armed;

  result_t expected_responses[$];
  int      error_count = 0;
  bit      idle_enable = 1'b1;

  function automatic in_item_t make_event(logic [1:0] op, logic gc, logic [7:0] rx);
    in_item_t it;
    it.opcode       = op;
    it.general_call = gc;
    it.rx_byte      = rx;
    return it;
  endfunction

  function automatic result_t predict_bus_response(in_item_t it);
    result_t r;
    r = '0;
    case (it.opcode)
      OP_WR_MATCH: begin
        if (it.general_call) broadcast_pending = 1'b1;
        offset_pending = 1'b1;
      end
      OP_DATA: begin
        if (offset_pending && !broadcast_pending) begin
          offset_pending = 1'b0;
          data_pending   = 1'b1;
          if (it.rx_byte == CHAR_ARM_READ) begin
            read_armed = 1'b1;
          end else begin
            read_armed     = 1'b0;
            shadow_pointer = shadow_pointer + it.rx_byte;
          end
        end else if (data_pending && !read_armed && !broadcast_pending) begin
          shadow_store[shadow_pointer] = it.rx_byte;
          offset_pending = 1'b0;
          data_pending   = 1'b0;
          shadow_pointer = '0;
        end else if (data_pending && read_armed && !broadcast_pending) begin
          shadow_pointer = shadow_pointer + it.rx_byte;
          offset_pending = 1'b0;
          data_pending   = 1'b0;
        end else if (broadcast_pending) begin
          broadcast_pending = 1'b0;
          offset_pending    = 1'b0;
          data_pending      = 1'b0;
          if (it.rx_byte == CHAR_RESET) begin
            shadow_store[1] = '0;
            r.led_off = 1'b1;
          end
        end
      end
      OP_RD_MATCH: begin
        r.tx_valid     = 1'b1;
        r.tx_byte      = shadow_store[shadow_pointer];
        shadow_pointer = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_event(in_item_t it);
    start     <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (busy);
    expected_responses.push_back(predict_bus_response(it));
    if (idle_enable && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_responses.size() != 0);
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (expected_responses.size() == 0) begin
        $error("unexpected response %h", result_o);
        error_count++;
      end else begin
        exp_r = expected_responses.pop_front();
        if (result_o.tx_valid !== exp_r.tx_valid) begin
          $error("tx_valid expected %b actual %b", exp_r.tx_valid, result_o.tx_valid);
          error_count++;
        end
        if (result_o.tx_byte !== exp_r.tx_byte) begin
          $error("tx_byte expected %h actual %h", exp_r.tx_byte, result_o.tx_byte);
          error_count++;
        end
        if (result_o.led_off !== exp_r.led_off) begin
          $error("led_off expected %b actual %b", exp_r.led_off, result_o.led_off);
          error_count++;
        end
      end
    end
  end

  task automatic write_register(logic [7:0] offset, logic [7:0] value);
    send_event(make_event(OP_WR_MATCH, 1'b0, 8'h00));
    send_event(make_event(OP_DATA, 1'b0, offset));
    send_event(make_event(OP_DATA, 1'b0, value));
  endtask

  task automatic armed_read(logic [7:0] advance_by);
    send_event(make_event(OP_WR_MATCH, 1'b0, 8'hFF));
    send_event(make_event(OP_DATA, 1'b1, CHAR_ARM_READ));
    send_event(make_event(OP_DATA, 1'b0, advance_by));
    send_event(make_event(OP_RD_MATCH, 1'b1, 8'hFF));
  endtask

  task automatic test_write_extremes();
    write_register(8'h00, 8'hFF);
    write_register(8'hFF, 8'h00);
    armed_read(8'h00);
    armed_read(8'hFF);
  endtask

  task automatic test_pointer_wrap();
    send_event(make_event(OP_WR_MATCH, 1'b0, 8'h00));
    send_event(make_event(OP_DATA, 1'b0, CHAR_ARM_READ));
    send_event(make_event(OP_DATA, 1'b0, 8'hF0));
    write_register(8'h20, 8'hA5);
    armed_read(8'h10);
  endtask

  task automatic test_general_call();
    write_register(8'h01, 8'h77);
    send_event(make_event(OP_WR_MATCH, 1'b1, 8'h00));
    send_event(make_event(OP_DATA, 1'b0, CHAR_RESET));
    armed_read(8'h01);
    send_event(make_event(OP_WR_MATCH, 1'b1, 8'h00));
    send_event(make_event(OP_DATA, 1'b0, 8'h33));
    send_event(make_event(OP_WR_MATCH, 1'b1, 8'h00));
    send_event(make_event(OP_WR_MATCH, 1'b0, 8'h00));
    send_event(make_event(OP_DATA, 1'b0, CHAR_RESET));
  endtask

  task automatic test_stray_and_unused();
    send_event(make_event(OP_DATA, 1'b1, 8'h5A));
    send_event(make_event(OP_UNUSED, 1'b1, 8'hFF));
    send_event(make_event(OP_WR_MATCH, 1'b0, 8'h00));
    send_event(make_event(OP_RD_MATCH, 1'b0, 8'h00));
    send_event(make_event(OP_DATA, 1'b0, 8'h02));
  endtask

  function automatic logic [7:0] pick_offset();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_traffic();
    int sent;
    int seq;
    int kind;
    sent = 0;
    seq  = 0;
    while (sent < 550) begin
      idle_enable = !(seq >= 60 && seq < 120);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_event(make_event(OP_WR_MATCH, 1'b0, 8'($urandom)));
        send_event(make_event(OP_DATA, 1'($urandom), pick_offset()));
        send_event(make_event(OP_DATA, 1'($urandom), 8'($urandom)));
        sent += 3;
      end else if (kind < 50) begin
        send_event(make_event(OP_WR_MATCH, 1'b0, 8'($urandom)));
        send_event(make_event(OP_DATA, 1'($urandom), CHAR_ARM_READ));
        send_event(make_event(OP_DATA, 1'($urandom), pick_offset()));
        send_event(make_event(OP_RD_MATCH, 1'($urandom), 8'($urandom)));
        sent += 4;
      end else if (kind < 60) begin
        send_event(make_event(OP_RD_MATCH, 1'($urandom), 8'($urandom)));
        sent += 1;
      end else if (kind < 72) begin
        send_event(make_event(OP_WR_MATCH, 1'b1, 8'($urandom)));
        send_event(make_event(OP_DATA, 1'($urandom),
                              $urandom_range(0, 1) ? CHAR_RESET : 8'($urandom)));
        sent += 2;
      end else begin
        send_event(make_event(2'($urandom), 1'($urandom), 8'($urandom)));
        sent += 1;
      end
      if (seq % 100 == 99) wait_drained();
      seq++;
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = '0;
    shadow_pointer    = '0;
    offset_pending    = 1'b0;
    data_pending      = 1'b0;
    broadcast_pending = 1'b0;
    read_armed        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_write_extremes();
    test_pointer_wrap();
    wait_drained();
    test_general_call();
    test_stray_and_unused();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("i2c_target_register_file_core test passed");
    end else begin
      $display("i2c_target_register_file_core test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("i2c_target_register_file_core test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/i2ctrf_pkg.sv
sv/i2ctrf_ram.sv
sv/i2ctrf_ctrl.sv
sv/i2ctrf_dp.sv
sv/i2c_target_register_file_core.sv
sv/i2ctrf_chk.sv
bench/i2c_target_register_file_core_tb.sv
